### hdl/pfa_pkg.sv
package pfa_pkg;

  localparam int ADDR_W   = 32;
  localparam int CNT_W    = 13;
  localparam int STAT_W   = 2;
  localparam int WORD_W   = 64;
  localparam int WORD_SH  = 6;

  localparam logic [ADDR_W-1:0] RESET_BASE  = 32'h0010_0000;
  localparam int                RESET_PAGES = 4096;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_OOM     = 2'd1;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;

  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_PAGES = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] page_address;
  } pfa_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] granted_address;
    logic [CNT_W-1:0]  pages_in_use;
  } pfa_out_t;

  typedef struct packed {
    logic cap_in;
    logic scan_start;
    logic scan_rd;
    logic clr_wr;
    logic hit_cap;
    logic alloc_wr;
    logic set_oom;
    logic set_inv;
    logic free_calc;
    logic free_rd;
    logic free_wr;
    logic out_load;
  } pfa_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic found;
    logic past_end;
    logic free_bad;
    logic out_free;
  } pfa_sts_t;

endpackage

### hdl/pfa_ctrl.sv
module pfa_ctrl import pfa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_req,
  output logic     in_stall,
  input  pfa_sts_t sts,
  output pfa_cmd_t cmd
);

  localparam logic [2:0] S_CLEAR     = 3'd0;
  localparam logic [2:0] S_IDLE      = 3'd1;
  localparam logic [2:0] S_SCAN      = 3'd2;
  localparam logic [2:0] S_ALLOC_WR  = 3'd3;
  localparam logic [2:0] S_FREE_CALC = 3'd4;
  localparam logic [2:0] S_FREE_RD   = 3'd5;
  localparam logic [2:0] S_FREE_CHK  = 3'd6;
  localparam logic [2:0] S_FINISH    = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          if (in_req == REQ_ALLOC) begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end else begin
            state_nxt = S_FREE_CALC;
          end
        end
      end
      S_SCAN: begin
        // One map word is read per cycle; the word read last cycle is examined now.
        if (sts.found) begin
          cmd.hit_cap = 1'b1;
          state_nxt   = S_ALLOC_WR;
        end else if (sts.past_end) begin
          cmd.set_oom = 1'b1;
          state_nxt   = S_FINISH;
        end else begin
          cmd.scan_rd = 1'b1;
        end
      end
      S_ALLOC_WR: begin
        cmd.alloc_wr = 1'b1;
        state_nxt    = S_FINISH;
      end
      S_FREE_CALC: begin
        cmd.free_calc = 1'b1;
        state_nxt     = S_FREE_RD;
      end
      S_FREE_RD: begin
        if (sts.free_bad) begin
          cmd.set_inv = 1'b1;
          state_nxt   = S_FINISH;
        end else begin
          cmd.free_rd = 1'b1;
          state_nxt   = S_FREE_CHK;
        end
      end
      S_FREE_CHK: begin
        cmd.free_wr = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hdl/pfa_dpath.sv
module pfa_dpath import pfa_pkg::*; #(
  parameter int MAX_PAGES  = 4096,
  parameter int PAGE_SHIFT = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pfa_in_t           in_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [ADDR_W-1:0] cfg_data,
  input  pfa_cmd_t          cmd,
  output pfa_sts_t          sts,
  input  logic              out_stall,
  output logic              out_valid,
  output pfa_out_t          out_data
);

  localparam int WORDS    = (MAX_PAGES + WORD_W - 1) / WORD_W;
  localparam int WORD_AW  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PTR_W    = $clog2(WORDS + 1);
  localparam int PAGE_W   = $clog2(MAX_PAGES + 1);
  localparam int LIM_W    = (PAGE_W > CNT_W) ? PAGE_W : CNT_W;
  localparam int SPAN_W   = $clog2(WORDS * WORD_W + 1);
  localparam int S_W      = (SPAN_W > LIM_W) ? SPAN_W : LIM_W;
  localparam int IDX_W    = ADDR_W - PAGE_SHIFT;
  localparam int CMP_W    = (IDX_W > LIM_W) ? IDX_W : LIM_W;
  localparam int RST_LIM  = (RESET_PAGES > MAX_PAGES) ? MAX_PAGES : RESET_PAGES;

  logic [WORD_W-1:0]  mem [WORDS];

  logic [PTR_W-1:0]   ptr_r;
  logic [PTR_W-1:0]   tag_r;
  logic [WORD_W-1:0]  data_r;
  logic               data_vld_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [ADDR_W-1:0]  base_r;
  logic [LIM_W-1:0]   limit_r;
  logic [CNT_W-1:0]   count_r;
  logic               below_r;
  logic [IDX_W-1:0]   idx_r;
  logic [S_W-1:0]     hit_page_r;
  logic [WORD_SH-1:0] hit_bit_r;
  logic [STAT_W-1:0]  res_status_r;
  logic [ADDR_W-1:0]  res_addr_r;
  logic               out_valid_r;
  pfa_out_t           out_data_r;

  logic [CNT_W-1:0]   pages_cfg;
  logic [LIM_W-1:0]   limit_nxt;
  logic [S_W-1:0]     word_start;
  logic [S_W-1:0]     avail;
  logic               avail_all;
  logic [WORD_W-1:0]  free_vec;
  logic [WORD_SH-1:0] free_pos;
  logic               past_end;
  logic [WORD_AW-1:0] free_word;
  logic               free_hit;
  logic [ADDR_W-1:0]  offset;
  logic               rd_en;
  logic [WORD_AW-1:0] rd_addr;
  logic               wr_en;
  logic [WORD_AW-1:0] wr_addr;
  logic [WORD_W-1:0]  wr_data;

  // Page count writes above the map capacity are clamped once, at the write.
  assign pages_cfg = cfg_data[CNT_W-1:0];
  assign limit_nxt = (LIM_W'(pages_cfg) > LIM_W'(MAX_PAGES)) ? LIM_W'(MAX_PAGES)
                                                              : LIM_W'(pages_cfg);

  // Scan word examination: pages at or past the limit count as taken.
  assign word_start = S_W'(tag_r) << WORD_SH;
  assign past_end   = (word_start >= S_W'(limit_r));
  assign avail      = S_W'(limit_r) - word_start;
  assign avail_all  = |avail[S_W-1:WORD_SH];

  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      free_vec[j] = ~data_r[j] & (avail_all | (WORD_SH'(j) < avail[WORD_SH-1:0]));
    end
  end

  always_comb begin
    free_pos = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (free_vec[j]) free_pos = WORD_SH'(j);
    end
  end

  assign offset    = addr_r - base_r;
  assign free_word = WORD_AW'(idx_r >> WORD_SH);
  assign free_hit  = data_r[idx_r[WORD_SH-1:0]];

  assign sts.clr_last = (ptr_r == PTR_W'(WORDS - 1));
  assign sts.found    = data_vld_r & ~past_end & (|free_vec);
  assign sts.past_end = data_vld_r & past_end;
  assign sts.free_bad = below_r | (CMP_W'(idx_r) >= CMP_W'(limit_r));
  assign sts.out_free = ~out_valid_r | ~out_stall;

  assign rd_en   = cmd.scan_rd | cmd.free_rd;
  assign rd_addr = cmd.scan_rd ? ptr_r[WORD_AW-1:0] : free_word;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_r[WORD_AW-1:0];
    wr_data = '0;
    if (cmd.clr_wr) begin
      wr_en = 1'b1;
    end else if (cmd.alloc_wr) begin
      wr_en   = 1'b1;
      wr_addr = tag_r[WORD_AW-1:0];
      wr_data = data_r | (WORD_W'(1) << hit_bit_r);
    end else if (cmd.free_wr) begin
      wr_en   = free_hit;
      wr_addr = free_word;
      wr_data = data_r & ~(WORD_W'(1) << idx_r[WORD_SH-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      data_r <= mem[rd_addr];
      tag_r  <= cmd.scan_rd ? ptr_r : tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      data_vld_r  <= 1'b0;
      count_r     <= '0;
      base_r      <= RESET_BASE;
      limit_r     <= LIM_W'(RST_LIM);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_BASE) base_r <= cfg_data;
        else limit_r <= limit_nxt;
      end
      if (cmd.scan_start) begin
        ptr_r      <= '0;
        data_vld_r <= 1'b0;
      end else if (cmd.scan_rd) begin
        ptr_r      <= ptr_r + 1'b1;
        data_vld_r <= 1'b1;
      end else if (cmd.clr_wr) begin
        ptr_r <= ptr_r + 1'b1;
      end
      if (cmd.alloc_wr) count_r <= count_r + 1'b1;
      else if (cmd.free_wr && free_hit) count_r <= count_r - 1'b1;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) addr_r <= in_data.page_address;
    if (cmd.free_calc) begin
      below_r <= (addr_r < base_r);
      idx_r   <= offset[ADDR_W-1:PAGE_SHIFT];
    end
    if (cmd.hit_cap) begin
      hit_page_r <= word_start + S_W'(free_pos);
      hit_bit_r  <= free_pos;
    end
    if (cmd.alloc_wr) begin
      res_status_r <= ST_DONE;
      res_addr_r   <= base_r + (ADDR_W'(hit_page_r) << PAGE_SHIFT);
    end else if (cmd.free_wr) begin
      res_status_r <= ST_DONE;
      res_addr_r   <= '0;
    end else if (cmd.set_oom) begin
      res_status_r <= ST_OOM;
      res_addr_r   <= '0;
    end else if (cmd.set_inv) begin
      res_status_r <= ST_INVALID;
      res_addr_r   <= '0;
    end
    if (cmd.out_load) begin
      out_data_r.status          <= res_status_r;
      out_data_r.granted_address <= res_addr_r;
      out_data_r.pages_in_use    <= count_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hdl/page_frame_allocator_unit.sv
// First-fit page allocator over a used map of MAX_PAGES pages, kept as 64-bit words in an
// on-chip memory. After reset the map is cleared one word per cycle, and no item is taken
// until that pass ends; configuration writes are accepted at any time. An allocate reads one
// map word per cycle from word 0 and stops at the first word with a free page below the page
// limit, or reports out of memory once it passes the limit with no page below it free. A free
// whose address falls outside the managed pages is rejected without reading the map. One item
// is in work at a time; a finished result sits in the output register, so the next item may
// start while it waits to be taken.
module page_frame_allocator_unit import pfa_pkg::*; #(
  parameter int MAX_PAGES  = 4096,
  parameter int PAGE_SHIFT = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pfa_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pfa_out_t          out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [ADDR_W-1:0] cfg_data
);

  pfa_cmd_t cmd;
  pfa_sts_t sts;

  assign cfg_ready = 1'b1;

  pfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_req   (in_data.req_type),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pfa_dpath #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

### tb/tb_page_frame_allocator_unit.sv
module tb_page_frame_allocator_unit;
  import pfa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PAGES  = 4096;
  localparam int PAGE_SHIFT = 12;
  localparam int HANG_LIMIT = 4000;
  localparam int DRAIN_WAIT = 80;
  localparam int HOLD_LEN   = 400;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  pfa_in_t           in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  pfa_out_t          out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_index = CFG_BASE;
  logic [ADDR_W-1:0] cfg_data = '0;

  page_frame_allocator_unit #(
    .MAX_PAGES (MAX_PAGES),
    .PAGE_SHIFT(PAGE_SHIFT)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the allocator state.
  bit   [MAX_PAGES-1:0] page_taken = '0;
  logic [CNT_W-1:0]     used_shadow = '0;
  logic [ADDR_W-1:0]    cur_base = RESET_BASE;
  logic [CNT_W-1:0]     cur_count = CNT_W'(RESET_PAGES);

  pfa_in_t  pending_items[$];
  pfa_out_t expected_results[$];

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   items_accepted = 0;
  int   mismatches = 0;
  logic in_taken = 1'b0;

  function automatic pfa_out_t serve_request(pfa_in_t req);
    int                limit;
    int                slot;
    bit                found;
    logic [ADDR_W-1:0] offset;
    pfa_out_t          res;
    limit = (cur_count > MAX_PAGES) ? MAX_PAGES : int'(cur_count);
    found = 1'b0;
    slot = 0;
    res.status = ST_DONE;
    res.granted_address = '0;
    if (req.req_type == REQ_ALLOC) begin
      for (int i = 0; i < limit; i++) begin
        if (!page_taken[i]) begin
          found = 1'b1;
          slot = i;
          break;
        end
      end
      if (found) begin
        page_taken[slot] = 1'b1;
        used_shadow = used_shadow + 1'b1;
        res.granted_address = cur_base + (ADDR_W'(slot) << PAGE_SHIFT);
      end else begin
        res.status = ST_OOM;
      end
    end else begin
      if (req.page_address < cur_base) begin
        res.status = ST_INVALID;
      end else begin
        offset = req.page_address - cur_base;
        slot = int'(offset >> PAGE_SHIFT);
        if (slot >= limit) begin
          res.status = ST_INVALID;
        end else if (page_taken[slot]) begin
          page_taken[slot] = 1'b0;
          used_shadow = used_shadow - 1'b1;
        end
      end
    end
    res.pages_in_use = used_shadow;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
  endtask

  // Monitor: predicts on every accepted item and checks every accepted result.
  always @(posedge clk) begin : monitor
    pfa_out_t want;
    if (rst_n) begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        expected_results.push_back(serve_request(in_data));
        items_accepted++;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_data.granted_address, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", ADDR_W'(out_data.status), ADDR_W'(want.status));
          if (out_data.granted_address !== want.granted_address)
            report_mismatch("granted_address", out_data.granted_address, want.granted_address);
          if (out_data.pages_in_use !== want.pages_in_use)
            report_mismatch("pages_in_use", ADDR_W'(out_data.pages_in_use),
                            ADDR_W'(want.pages_in_use));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BASE) cur_base = cfg_data;
        else cur_count = cfg_data[CNT_W-1:0];
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Driver: offers queued items, keeping each one steady until it is taken.
  always @(negedge clk) begin : driver
    logic    nxt_valid;
    pfa_in_t nxt_data;
    nxt_valid = in_valid;
    nxt_data = in_data;
    if (in_taken) nxt_valid = 1'b0;
    if (!nxt_valid && pending_items.size() != 0 &&
        $urandom_range(99) >= send_idle_pct) begin
      nxt_data = pending_items.pop_front();
      nxt_valid = 1'b1;
    end
    in_valid <= nxt_valid;
    in_data <= nxt_data;
  end

  // Receiver: random stalls, plus two long hold-offs so the block backs up.
  int hold_left = 0;
  int holds_done = 0;
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && items_accepted >= 60 + holds_done * 440) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_LEN;
      holds_done <= holds_done + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic queue_alloc();
    pending_items.push_back('{req_type: REQ_ALLOC, page_address: ADDR_W'($urandom)});
  endtask

  task automatic queue_free(logic [ADDR_W-1:0] addr);
    pending_items.push_back('{req_type: REQ_FREE, page_address: addr});
  endtask

  task automatic write_reg(logic idx, logic [ADDR_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  initial begin
    logic [ADDR_W-1:0] base_sel;
    logic [CNT_W-1:0]  count_sel;
    int                pick;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    set_idling(26, 68);

    // Reset settings: edges of the managed window, unaligned and stray addresses.
    queue_free(RESET_BASE);
    queue_free(RESET_BASE - 1);
    queue_free(RESET_BASE + (ADDR_W'(RESET_PAGES) << PAGE_SHIFT));
    queue_alloc();
    queue_alloc();
    queue_alloc();
    queue_free(RESET_BASE + 32'h0000_1FFF);
    queue_alloc();
    queue_free(32'hFFFF_FFFF);
    queue_free(32'h0000_0000);
    queue_free(RESET_BASE + (ADDR_W'(RESET_PAGES - 1) << PAGE_SHIFT));
    wait_idle();

    // No managed pages at all.
    write_reg(CFG_PAGES, 32'd0);
    @(posedge clk);
    queue_alloc();
    queue_free(RESET_BASE);
    wait_idle();

    // Window shrunk below pages still marked used: full map at once.
    write_reg(CFG_PAGES, 32'd2);
    @(posedge clk);
    queue_alloc();
    queue_free(RESET_BASE + 32'h0000_2000);
    queue_free(RESET_BASE + 32'h0000_1000);
    queue_alloc();
    wait_idle();

    // Base near the top so grants wrap; page count above capacity.
    write_reg(CFG_BASE, 32'hFFFF_F000);
    write_reg(CFG_PAGES, 32'd5000);
    @(posedge clk);
    queue_alloc();
    queue_free(32'h0000_2000);
    queue_free(32'hFFFF_F000);
    queue_alloc();
    queue_free(32'hFFFF_FFFF);
    wait_idle();

    write_reg(CFG_BASE, 32'h0000_0000);
    write_reg(CFG_PAGES, 32'h0000_1FFF);
    @(posedge clk);
    queue_free(32'h0000_0000);
    queue_alloc();
    wait_idle();

    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 3) set_idling(68, 26);
      else if (phase == 6) set_idling(0, 0);
      base_sel = (phase == 0) ? 32'h0000_0000 :
                 (phase == 1) ? 32'hFFFF_FFFF : ADDR_W'($urandom);
      count_sel = (phase == 2) ? CNT_W'(MAX_PAGES) :
                  (phase == 5) ? CNT_W'(8191) : CNT_W'($urandom_range(1, 96));
      write_reg(CFG_BASE, base_sel);
      write_reg(CFG_PAGES, ADDR_W'(count_sel));
      @(posedge clk);
      // Mostly allocates and frees inside the window, some stray addresses.
      for (int n = 0; n < 100; n++) begin
        pick = $urandom_range(99);
        if (pick < 50) begin
          queue_alloc();
        end else if (pick < 85) begin
          queue_free(base_sel + (ADDR_W'($urandom_range(0, count_sel)) << PAGE_SHIFT)
                     + ADDR_W'($urandom_range(0, 4095)));
        end else begin
          queue_free(ADDR_W'($urandom));
        end
      end
      wait_idle();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
